// File: hw/rtl/prf_pkg.sv
package prf_pkg;

  localparam int PREFIX_LEN = 7;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       line_end;
    logic       line_dropped;
  } prf_result_t;

  // Expected byte of the "+HYFIX," prefix at a given match position.
  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h2B;
      3'd1: b = 8'h48;
      3'd2: b = 8'h59;
      3'd3: b = 8'h46;
      3'd4: b = 8'h49;
      3'd5: b = 8'h58;
      3'd6: b = 8'h2C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/prf_framer_core.sv
module prf_framer_core
  import prf_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  c,
  output prf_result_t res
);

  localparam int LenW = $clog2(MAX_LINE + 1);
  localparam logic [LenW-1:0] PrefixLen = LenW'(PREFIX_LEN);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_LINE);
  localparam logic [LenW-1:0] LenOne = LenW'(1);

  logic [LenW-1:0] line_length;
  logic [LenW-1:0] line_length_next;
  logic [7:0]      held_byte;
  logic [7:0]      held_byte_next;
  logic            held_valid;
  logic            held_valid_next;

  logic len_zero;
  logic prefix_open;

  assign len_zero    = (line_length == '0);
  assign prefix_open = (line_length < PrefixLen);

  always_comb begin
    res              = '0;
    line_length_next = line_length;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    if (c == CH_NL) begin
      if (len_zero) begin
        line_length_next = line_length;
      end else if (prefix_open) begin
        line_length_next = '0;
        res.line_dropped = 1'b1;
      end else begin
        if (held_valid && (held_byte != CH_CR)) begin
          res.out_byte       = held_byte;
          res.out_byte_valid = 1'b1;
        end
        res.line_end     = 1'b1;
        line_length_next = '0;
        held_valid_next  = 1'b0;
      end
    end else if ((c == CH_PLUS) && prefix_open) begin
      line_length_next = LenOne;
    end else if (len_zero) begin
      line_length_next = line_length;
    end else if (prefix_open) begin
      if (c == prefix_byte(line_length[2:0])) begin
        line_length_next = line_length + LenOne;
      end else begin
        line_length_next = '0;
      end
    end else if (line_length >= MaxLen) begin
      line_length_next = '0;
      held_valid_next  = 1'b0;
      res.line_dropped = 1'b1;
    end else begin
      line_length_next = line_length + LenOne;
      if (held_valid) begin
        res.out_byte       = held_byte;
        res.out_byte_valid = 1'b1;
      end
      held_byte_next  = c;
      held_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      held_valid  <= 1'b0;
    end else if (step) begin
      line_length <= line_length_next;
      held_valid  <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_byte <= held_byte_next;
    end
  end

  a_hold_only_in_content: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (line_length >= PrefixLen))
    else $error("Hold occupied while no prefix is complete.");

  a_length_bounded: assert property (@(posedge clk) disable iff (rst)
    line_length <= MaxLen)
    else $error("Line length beyond the maximum.");

  a_end_or_drop: assert property (@(posedge clk) disable iff (rst)
    step |-> !(res.line_end && res.line_dropped))
    else $error("A line both ended and dropped.");

  a_emit_from_hold: assert property (@(posedge clk) disable iff (rst)
    (step && res.out_byte_valid) |-> held_valid)
    else $error("Byte emitted with an empty hold.");

endmodule

// File: hw/rtl/prefix_resync_reply_framer_unit.sv
// Frames "+HYFIX," reply lines out of a mixed binary and text byte stream.
// Input channel: one rx_byte per item, accepted when in_valid is high and
// in_stall is low. Output channel: exactly one result item per input item,
// taken when out_valid is high and out_stall is low, carrying out_byte,
// out_byte_valid, line_end and line_dropped.
// Each item passes through an input register and then the framing logic into
// the result register, from which its result is offered. The block takes one
// item per cycle while the result is taken; the single output register sets
// that figure.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall then rises until the output side moves again.
// Reset clears both valid flags, the line length and the one-byte hold, so
// the block starts with no line open and nothing held.
module prefix_resync_reply_framer_unit
  import prf_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       line_end,
  output logic       line_dropped
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_ready;
  logic        step;
  prf_result_t res;
  prf_result_t out_res;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_ready;
  assign step      = s1_valid && out_ready;

  prf_framer_core #(
    .MAX_LINE(MAX_LINE)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .step(step),
    .c   (s1_byte),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign out_byte       = out_res.out_byte;
  assign out_byte_valid = out_res.out_byte_valid;
  assign line_end       = out_res.line_end;
  assign line_dropped   = out_res.line_dropped;

  a_no_loss_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("Result changed while the receiver stalled.");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("Item left the input register without reaching the output.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("Input stalled while a stage was free.");

endmodule

// File: dv/prefix_resync_reply_framer_unit_tb.sv
module prefix_resync_reply_framer_unit_tb;
  import prf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT = 256;
  localparam int RANDOM_ITEMS = 1250;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;

  localparam logic [7:0] REPLY_PREFIX [7] = '{8'h2B, 8'h48, 8'h59, 8'h46, 8'h49, 8'h58, 8'h2C};

  localparam prf_result_t NO_REPLY = '0;
  localparam prf_result_t LINE_DROP =
    '{out_byte: 8'h00, out_byte_valid: 1'b0, line_end: 1'b0, line_dropped: 1'b1};
  localparam prf_result_t LINE_DONE =
    '{out_byte: 8'h00, out_byte_valid: 1'b0, line_end: 1'b1, line_dropped: 1'b0};

  typedef struct packed {
    logic [7:0]  rx;
    logic        has_res;
    prf_result_t res;
  } stim_row_t;

  localparam stim_row_t DIRECTED [28] = '{
    '{8'h00, 1'b1, NO_REPLY},
    '{CH_NL, 1'b1, NO_REPLY},
    '{CH_PLUS, 1'b0, NO_REPLY},
    '{8'h48, 1'b0, NO_REPLY},
    '{8'h58, 1'b0, NO_REPLY},
    '{CH_PLUS, 1'b0, NO_REPLY},
    '{CH_PLUS, 1'b0, NO_REPLY},
    '{CH_NL, 1'b1, LINE_DROP},
    '{CH_PLUS, 1'b0, NO_REPLY},
    '{8'h48, 1'b0, NO_REPLY},
    '{8'h59, 1'b0, NO_REPLY},
    '{8'h46, 1'b0, NO_REPLY},
    '{8'h49, 1'b0, NO_REPLY},
    '{8'h58, 1'b0, NO_REPLY},
    '{8'h2C, 1'b0, NO_REPLY},
    '{CH_NL, 1'b1, LINE_DONE},
    '{CH_PLUS, 1'b0, NO_REPLY},
    '{8'h48, 1'b0, NO_REPLY},
    '{8'h59, 1'b0, NO_REPLY},
    '{8'h46, 1'b0, NO_REPLY},
    '{8'h49, 1'b0, NO_REPLY},
    '{8'h58, 1'b0, NO_REPLY},
    '{8'h2C, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{CH_CR, 1'b0, NO_REPLY},
    '{CH_PLUS, 1'b0, NO_REPLY},
    '{CH_CR, 1'b0, NO_REPLY},
    '{CH_NL, 1'b0, NO_REPLY}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_byte_valid;
  logic line_end;
  logic line_dropped;

  logic row_has_res = 1'b0;
  prf_result_t row_res = '0;

  int unsigned line_len = 0;
  logic [7:0] hold_byte = 8'h00;
  logic hold_full = 1'b0;

  prf_result_t expected_replies[$];
  int fail_count = 0;
  int n_sent = 0;
  int n_in = 0;
  int n_out = 0;
  int n_ended = 0;
  int n_dropped = 0;
  int n_bytes = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_on = 1'b0;
  bit hold_done = 1'b0;

  prefix_resync_reply_framer_unit #(.MAX_LINE(LINE_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_byte_valid(out_byte_valid),
    .line_end(line_end),
    .line_dropped(line_dropped)
  );

  always #5ns clk = ~clk;

  function automatic prf_result_t frame_next_reply(input logic [7:0] c);
    prf_result_t r;
    r = '0;
    if (c == CH_NL) begin
      if (line_len != 0 && line_len < PREFIX_LEN) begin
        r.line_dropped = 1'b1;
        line_len = 0;
      end else if (line_len >= PREFIX_LEN) begin
        r.line_end = 1'b1;
        if (hold_full && hold_byte != CH_CR) begin
          r.out_byte = hold_byte;
          r.out_byte_valid = 1'b1;
        end
        line_len = 0;
        hold_full = 1'b0;
        hold_byte = 8'h00;
      end
    end else if (c == CH_PLUS && line_len < PREFIX_LEN) begin
      line_len = 1;
    end else if (line_len != 0) begin
      if (line_len < PREFIX_LEN) begin
        if (c == REPLY_PREFIX[line_len[2:0]]) line_len++;
        else line_len = 0;
      end else if (line_len + 1 > LINE_LIMIT) begin
        line_len = 0;
        hold_full = 1'b0;
        hold_byte = 8'h00;
        r.line_dropped = 1'b1;
      end else begin
        line_len++;
        if (hold_full) begin
          r.out_byte = hold_byte;
          r.out_byte_valid = 1'b1;
        end
        hold_byte = c;
        hold_full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic has_res, input prf_result_t res);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || hold_on) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    row_has_res <= has_res;
    row_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    prf_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = frame_next_reply(rx_byte);
        if (row_has_res) want = row_res;
        expected_replies.push_back(want);
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (line_end) n_ended++;
        if (line_dropped) n_dropped++;
        if (out_byte_valid) n_bytes++;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result: out_byte %02h valid %0b end %0b dropped %0b",
                   $time, out_byte, out_byte_valid, line_end, line_dropped);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte, out_byte);
            fail_count++;
          end
          if (out_byte_valid !== want.out_byte_valid) begin
            $display("%0t: out_byte_valid expected %0b, got %0b",
                     $time, want.out_byte_valid, out_byte_valid);
            fail_count++;
          end
          if (line_end !== want.line_end) begin
            $display("%0t: line_end expected %0b, got %0b", $time, want.line_end, line_end);
            fail_count++;
          end
          if (line_dropped !== want.line_dropped) begin
            $display("%0t: line_dropped expected %0b, got %0b",
                     $time, want.line_dropped, line_dropped);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("prefix_resync_reply_framer_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      n = rx_burst ? 0 : $urandom_range(0, 17);
      if (!hold_done && n_out >= 500) begin
        hold_done = 1'b1;
        hold_on = 1'b1;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      hold_on = 1'b0;
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int kind;
    int len;
    int k;
    int n_lines;
    logic [7:0] b;
    n_lines = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].has_res, DIRECTED[i].res);
    drain_replies();

    while (n_sent < RANDOM_ITEMS + $size(DIRECTED)) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPLY);
      end else if (kind < 22) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) send_byte(REPLY_PREFIX[i], 1'b0, NO_REPLY);
        case ($urandom_range(0, 2))
          0: send_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPLY);
          1: send_byte(CH_NL, 1'b0, NO_REPLY);
          default: send_byte(CH_PLUS, 1'b0, NO_REPLY);
        endcase
      end else begin
        if (n_lines == 0) len = LINE_LIMIT - PREFIX_LEN + 1;
        else if (n_lines == 1) len = LINE_LIMIT - PREFIX_LEN;
        else if (kind < 25) len = $urandom_range(LINE_LIMIT - 20, LINE_LIMIT + 20);
        else len = $urandom_range(0, 40);
        for (int i = 0; i < PREFIX_LEN; i++) send_byte(REPLY_PREFIX[i], 1'b0, NO_REPLY);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) b = CH_CR;
          else begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
          end
          send_byte(b, 1'b0, NO_REPLY);
        end
        if ($urandom_range(0, 2) == 0) send_byte(CH_CR, 1'b0, NO_REPLY);
        send_byte(CH_NL, 1'b0, NO_REPLY);
        n_lines++;
        if (n_lines == 20) drain_replies();
      end
    end

    drain_replies();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d framed lines and noise; checked %0d results.",
             n_in, n_lines, n_out);
    $display("Seen %0d line ends, %0d dropped lines and %0d content bytes.",
             n_ended, n_dropped, n_bytes);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("prefix_resync_reply_framer_unit_tb: PASS");
    end else begin
      $display("prefix_resync_reply_framer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/prf_pkg.sv
hw/rtl/prf_framer_core.sv
hw/rtl/prefix_resync_reply_framer_unit.sv
dv/prefix_resync_reply_framer_unit_tb.sv
